### rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and types for the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int AngW  = 16;
    localparam int QW    = 16;
    localparam int CordW = 34;   // Q2.30 plus headroom
    localparam int ZW    = 34;   // residual, 2^32 per turn, signed
    localparam int AtanEntries = 24;
    localparam logic signed [CordW-1:0] GainInv = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        begin
            case (idx)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10679838;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670163;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [ZW-1:0]    z;
    } cord_t;

endpackage

### rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Heading/pitch/bank binary angles to a Q1.15 quaternion.
//
//  channel | signals                                    | marker
//  in      | req_type, heading/pitch/bank_angle         | start & !busy
//  out     | quat_w, quat_x, quat_y, quat_z             | done (one cycle)
//
// One beat per cycle; each beat passes through the input register, the CORDIC
// stage chain (CORDIC_STAGES, max 24) and three product/round stages.
// busy is always low. rst_n clears only the valid chain.
// The receiver cannot stall; done strobes for one cycle per beat.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic signed [15:0] heading_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] bank_angle,
    output logic        done,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z
);
    import e2q_pkg::*;

    localparam int NS  = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
    localparam int LAT = NS + 3;

    logic signed [QW:0] ch, sh, cp, sp, cb, sb;
    logic [LAT:0] vld_reg;
    logic [NS:0]  inv_reg;

    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_h (.clk(clk), .angle(heading_angle),
        .cos_q(ch), .sin_q(sh));
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_p (.clk(clk), .angle(pitch_angle),
        .cos_q(cp), .sin_q(sp));
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_b (.clk(clk), .angle(bank_angle),
        .cos_q(cb), .sin_q(sb));

    always_ff @(posedge clk)
    begin
        inv_reg <= {inv_reg[NS-1:0], req_type};
    end

    // advance the valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-1:0], start};
    end

    e2q_combine u_comb (.clk(clk), .ch(ch), .sh(sh), .cp(cp), .sp(sp), .cb(cb),
        .sb(sb), .inv(inv_reg[NS]), .quat_w(quat_w), .quat_x(quat_x),
        .quat_y(quat_y), .quat_z(quat_z));

    assign busy = 1'b0;
    assign done = vld_reg[LAT];

    a_busy_low: assert property (@(posedge clk) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> ##(LAT) done)
        else $error("beat lost in pipeline");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[LAT-1]))
        else $error("spurious done");

endmodule

### rtl/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of half a binary angle,
// one stage register per iteration.
// ----------------------------------------------------------------------------
module e2q_cordic #(
    parameter int STAGES = 16
) (
    input  logic                            clk,
    input  logic signed [e2q_pkg::AngW-1:0] angle,
    output logic signed [e2q_pkg::QW:0]     cos_q,
    output logic signed [e2q_pkg::QW:0]     sin_q
);
    import e2q_pkg::*;

    localparam int N = (STAGES < AtanEntries) ? STAGES : AtanEntries;

    cord_t st_reg [0:N];
    logic signed [CordW-1:0] xr, yr;

    always_ff @(posedge clk)
    begin
        st_reg[0].x <= GainInv;
        st_reg[0].y <= '0;
        st_reg[0].z <= ZW'(angle) <<< 15;
        for (int i = 0; i < N; i++)
        begin
            if (!st_reg[i].z[ZW-1])
            begin
                st_reg[i+1].x <= st_reg[i].x - (st_reg[i].y >>> i);
                st_reg[i+1].y <= st_reg[i].y + (st_reg[i].x >>> i);
                st_reg[i+1].z <= st_reg[i].z - atan_lut(5'(i));
            end
            else
            begin
                st_reg[i+1].x <= st_reg[i].x + (st_reg[i].y >>> i);
                st_reg[i+1].y <= st_reg[i].y - (st_reg[i].x >>> i);
                st_reg[i+1].z <= st_reg[i].z + atan_lut(5'(i));
            end
        end
    end

    // round to Q.15; |value| stays within 17 bits
    assign xr = (st_reg[N].x + CordW'(16384)) >>> 15;
    assign yr = (st_reg[N].y + CordW'(16384)) >>> 15;
    assign cos_q = xr[QW:0];
    assign sin_q = yr[QW:0];

endmodule

### rtl/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Triple products, sums, rounding, sign and saturation, three stages.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic                            clk,
    input  logic signed [e2q_pkg::QW:0]     ch, sh, cp, sp, cb, sb,
    input  logic                            inv,
    output logic signed [e2q_pkg::QW-1:0]   quat_w, quat_x, quat_y, quat_z
);
    import e2q_pkg::*;

    localparam int PW = 2*(QW+1);
    localparam int TW = 3*(QW+1);

    logic signed [PW-1:0] cc_reg, ss_reg, cs_reg, sc_reg;
    logic signed [QW:0]   cb_reg, sb_reg;
    logic                 inv1_reg, inv2_reg;
    logic signed [TW+1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    function automatic logic signed [QW-1:0] fin(input logic signed [TW+1:0] s,
                                                  input logic neg);
        logic signed [TW+1:0] v;
        begin
            v = (s + (TW+2)'(1 <<< 29)) >>> 30;
            if (neg) v = -v;
            if (v > (TW+2)'(32767)) v = (TW+2)'(32767);
            else if (v < -(TW+2)'(32768)) v = -(TW+2)'(32768);
            return v[QW-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        cc_reg   <= ch * cp;
        ss_reg   <= sh * sp;
        cs_reg   <= ch * sp;
        sc_reg   <= sh * cp;
        cb_reg   <= cb;
        sb_reg   <= sb;
        inv1_reg <= inv;
        w_reg    <= (TW+2)'(cc_reg * cb_reg) + (TW+2)'(ss_reg * sb_reg);
        x_reg    <= (TW+2)'(cs_reg * cb_reg) + (TW+2)'(sc_reg * sb_reg);
        y_reg    <= (TW+2)'(sc_reg * cb_reg) - (TW+2)'(cs_reg * sb_reg);
        z_reg    <= (TW+2)'(cc_reg * sb_reg) - (TW+2)'(ss_reg * cb_reg);
        inv2_reg <= inv1_reg;
        qw_reg   <= fin(w_reg, 1'b0);
        qx_reg   <= fin(x_reg, inv2_reg);
        qy_reg   <= fin(y_reg, inv2_reg);
        qz_reg   <= fin(z_reg, inv2_reg);
    end

    assign quat_w = qw_reg;
    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;

endmodule
